### rtl/ierf_pkg.sv
package ierf_pkg;

    localparam int unsigned IP_HDR_MIN_BYTES = 20;
    localparam int unsigned ICMP_HDR_BYTES   = 8;
    localparam logic [3:0]  IP_VERSION_4     = 4'd4;
    localparam logic [7:0]  IP_PROTO_ICMP    = 8'd1;
    localparam logic [7:0]  ICMP_ECHO_REPLY  = 8'd0;
    localparam logic [7:0]  ICMP_CODE_ZERO   = 8'd0;
    localparam logic [15:0] CSUM_GOOD        = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_VERSION = 3'd2,
        ST_HDRLEN  = 3'd3,
        ST_PROTO   = 3'd4,
        ST_CSUM    = 3'd5,
        ST_NOTOURS = 3'd6
    } t_status;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_beat;

    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [31:0] source_address;
    } t_result;

endpackage

### rtl/ierf_in_if.sv
interface ierf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/ierf_out_if.sv
interface ierf_out_if import ierf_pkg::*; ();
    logic        valid;
    logic        ready;
    t_status     status;
    logic [31:0] source_address;

    modport source (output valid, output status, output source_address, input ready);
    modport sink (input valid, input status, input source_address, output ready);
endinterface

### rtl/ierf_in_stage.sv
module ierf_in_stage import ierf_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ierf_in_if.sink        i_pkt,
    input  logic           i_take,
    output t_beat          o_beat
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    assign i_pkt.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pkt.valid && i_pkt.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pkt.valid && i_pkt.ready) begin
            r_byte <= i_pkt.data_byte;
            r_last <= i_pkt.last_byte;
        end
    end

    assign o_beat = '{valid: r_valid, data_byte: r_byte, last_byte: r_last};

endmodule

### rtl/ierf_parser.sv
module ierf_parser import ierf_pkg::*; #(
    parameter int unsigned MAX_PACKET_BYTES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  t_beat       i_beat,
    input  logic        i_out_free,
    output logic        o_take,
    output t_result     o_result
);

    localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PACKET_BYTES);

    function automatic logic [15:0] add_fold(input logic [15:0] acc, input logic [15:0] word);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, word};
        return s[15:0] + {15'b0, s[16]};
    endfunction

    logic [15:0]      r_echo_id;
    logic [CNT_W-1:0] r_count, n_count, u_count;
    logic [3:0]       r_hdr_words, n_hdr_words, u_hdr_words;
    logic [3:0]       r_version, n_version, u_version;
    logic [7:0]       r_proto, n_proto, u_proto;
    logic [31:0]      r_src, n_src, u_src;
    logic [15:0]      r_sum, n_sum, u_sum;
    logic [7:0]       r_hold, n_hold, u_hold;
    logic [7:0]       r_type, n_type, u_type;
    logic [7:0]       r_code, n_code, u_code;
    logic [15:0]      r_ident, n_ident, u_ident;

    logic [5:0]       hb;
    logic [CNT_W-1:0] hb_ext;
    logic [CNT_W-1:0] rel;
    logic [5:0]       fin_hb;
    logic [CNT_W-1:0] fin_hb_ext;
    logic [CNT_W-1:0] fin_diff;
    logic [15:0]      fin_sum;
    t_status          fin_status;
    logic             take_last;

    assign o_take    = i_beat.valid && (!i_beat.last_byte || i_out_free);
    assign take_last = o_take && i_beat.last_byte;

    always_comb begin
        u_count     = r_count;
        u_hdr_words = r_hdr_words;
        u_version   = r_version;
        u_proto     = r_proto;
        u_src       = r_src;
        u_sum       = r_sum;
        u_hold      = r_hold;
        u_type      = r_type;
        u_code      = r_code;
        u_ident     = r_ident;
        hb          = {r_hdr_words, 2'b00};
        if (r_count == '0) begin
            hb = {i_beat.data_byte[3:0], 2'b00};
        end
        hb_ext = CNT_W'(hb);
        rel    = r_count - hb_ext;
        if (o_take && (r_count < CNT_MAX)) begin
            if (r_count == '0) begin
                u_version   = i_beat.data_byte[7:4];
                u_hdr_words = i_beat.data_byte[3:0];
            end
            if (r_count == CNT_W'(9)) begin
                u_proto = i_beat.data_byte;
            end
            if ((r_count >= CNT_W'(12)) && (r_count <= CNT_W'(15))) begin
                u_src = {r_src[23:0], i_beat.data_byte};
            end
            if (r_count >= hb_ext) begin
                if (!rel[0]) begin
                    u_hold = i_beat.data_byte;
                end else begin
                    u_sum = add_fold(r_sum, {r_hold, i_beat.data_byte});
                end
                if (rel == CNT_W'(0)) begin
                    u_type = i_beat.data_byte;
                end
                if (rel == CNT_W'(1)) begin
                    u_code = i_beat.data_byte;
                end
                if ((rel == CNT_W'(4)) || (rel == CNT_W'(5))) begin
                    u_ident = {r_ident[7:0], i_beat.data_byte};
                end
            end
            u_count = r_count + CNT_W'(1);
        end
    end

    always_comb begin
        fin_hb     = {u_hdr_words, 2'b00};
        fin_hb_ext = CNT_W'(fin_hb);
        fin_diff   = u_count - fin_hb_ext;
        fin_sum    = fin_diff[0] ? add_fold(u_sum, {u_hold, 8'h00}) : u_sum;
        if (u_count < CNT_W'(IP_HDR_MIN_BYTES)) begin
            fin_status = ST_SHORT;
        end else if (u_version != IP_VERSION_4) begin
            fin_status = ST_VERSION;
        end else if ((fin_hb < 6'(IP_HDR_MIN_BYTES))
                     || (u_count < fin_hb_ext + CNT_W'(ICMP_HDR_BYTES))) begin
            fin_status = ST_HDRLEN;
        end else if (u_proto != IP_PROTO_ICMP) begin
            fin_status = ST_PROTO;
        end else if (fin_sum != CSUM_GOOD) begin
            fin_status = ST_CSUM;
        end else if ((u_type != ICMP_ECHO_REPLY) || (u_code != ICMP_CODE_ZERO)
                     || (u_ident != r_echo_id)) begin
            fin_status = ST_NOTOURS;
        end else begin
            fin_status = ST_OK;
        end
    end

    always_comb begin
        if (take_last) begin
            n_count     = '0;
            n_hdr_words = '0;
            n_version   = '0;
            n_proto     = '0;
            n_src       = '0;
            n_sum       = '0;
            n_hold      = '0;
            n_type      = '0;
            n_code      = '0;
            n_ident     = '0;
        end else begin
            n_count     = u_count;
            n_hdr_words = u_hdr_words;
            n_version   = u_version;
            n_proto     = u_proto;
            n_src       = u_src;
            n_sum       = u_sum;
            n_hold      = u_hold;
            n_type      = u_type;
            n_code      = u_code;
            n_ident     = u_ident;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_id   <= '0;
            r_count     <= '0;
            r_hdr_words <= '0;
            r_version   <= '0;
            r_proto     <= '0;
            r_src       <= '0;
            r_sum       <= '0;
            r_hold      <= '0;
            r_type      <= '0;
            r_code      <= '0;
            r_ident     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_echo_id <= i_cfg_wr_data;
            end
            r_count     <= n_count;
            r_hdr_words <= n_hdr_words;
            r_version   <= n_version;
            r_proto     <= n_proto;
            r_src       <= n_src;
            r_sum       <= n_sum;
            r_hold      <= n_hold;
            r_type      <= n_type;
            r_code      <= n_code;
            r_ident     <= n_ident;
        end
    end

    assign o_result = '{valid: take_last, status: fin_status, source_address: u_src};

endmodule

### rtl/ierf_out_stage.sv
module ierf_out_stage import ierf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_result     i_result,
    output logic        o_free,
    ierf_out_if.source  o_res
);

    logic        r_valid;
    t_status     r_status;
    logic [31:0] r_src;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_result.valid) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_status <= i_result.status;
            r_src    <= i_result.source_address;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.status         = r_status;
    assign o_res.source_address = r_src;

endmodule

### rtl/icmp_echo_reply_filter.sv
// ICMP echo reply filter.
// i_pkt carries one received IPv4 packet, one byte per transaction, header first,
// last_byte set on the final byte. o_res carries one transaction per packet:
// a status and the IPv4 source address, both taken at the final byte.
// i_cfg_wr_en / i_cfg_wr_data write the 16-bit echo identifier; write only while idle.
// Throughput: one byte per cycle unless a final byte waits for the result register;
// set by the single parse stage between the input register and the result register.
// The final byte is held in the input register, parsed, and its result is then
// registered in the result register, which drives o_res.valid.
// Bytes beyond MAX_PACKET_BYTES are dropped; the final mark still ends the packet.
// Reset: clears the identifier, all packet state and the valid flags of both stage registers.
// Stall on o_res: non-final bytes keep flowing; a final byte waits in the input
// register until the result register frees, and i_pkt.ready drops meanwhile.
module icmp_echo_reply_filter import ierf_pkg::*; #(
    parameter int unsigned MAX_PACKET_BYTES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    ierf_in_if.sink     i_pkt,
    ierf_out_if.source  o_res
);

    t_beat   beat;
    t_result result;
    logic    take;
    logic    out_free;

    ierf_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (i_pkt),
        .i_take  (take),
        .o_beat  (beat)
    );

    ierf_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_beat        (beat),
        .i_out_free    (out_free),
        .o_take        (take),
        .o_result      (result)
    );

    ierf_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (result),
        .o_free   (out_free),
        .o_res    (o_res)
    );

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(take && beat.last_byte))
        else $error("result appeared without a final byte");

    a_mid_byte_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (beat.valid && !beat.last_byte) |-> take)
        else $error("non-final byte stalled");

    a_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready && beat.valid && beat.last_byte) |-> !take)
        else $error("final byte taken while result stalled");

endmodule

### sim/icmp_echo_reply_filter_checker.sv
`timescale 1ns / 100ps

module icmp_echo_reply_filter_checker import ierf_pkg::*; #(
    parameter int unsigned MAX_PACKET_BYTES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_pkt_valid,
    input  logic        i_pkt_ready,
    input  logic [7:0]  i_pkt_data,
    input  logic        i_pkt_last,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  t_status     i_res_status,
    input  logic [31:0] i_res_source,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        t_status     status;
        logic [31:0] source;
    } t_verdict;

    t_verdict verdict_q[$];

    logic [15:0] own_ident;
    logic [11:0] byte_cnt;
    logic [3:0]  ihl;
    logic [3:0]  version;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [16:0] csum;
    logic [7:0]  hi_hold;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
    logic [15:0] rx_ident;

    function automatic logic [16:0] fold_add(input logic [16:0] acc, input logic [15:0] word);
        logic [16:0] s;
        s = {1'b0, acc[15:0]} + {1'b0, word};
        return {1'b0, s[15:0]} + {16'd0, s[16]};
    endfunction

    task automatic clear_packet();
        byte_cnt  = '0;
        ihl       = '0;
        version   = '0;
        proto     = '0;
        src_addr  = '0;
        csum      = '0;
        hi_hold   = '0;
        icmp_type = '0;
        icmp_code = '0;
        rx_ident  = '0;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        int unsigned idx;
        int unsigned hb;
        int unsigned rel;
        idx = byte_cnt;
        if (idx == 0) begin
            version = b[7:4];
            ihl     = b[3:0];
        end
        if (idx == 9) proto = b;
        if (idx >= 12 && idx <= 15) src_addr = {src_addr[23:0], b};
        hb = ihl * 4;
        if (idx >= hb) begin
            rel = idx - hb;
            if (rel[0] == 1'b0) hi_hold = b;
            else csum = fold_add(csum, {hi_hold, b});
            if (rel == 0) icmp_type = b;
            if (rel == 1) icmp_code = b;
            if (rel == 4 || rel == 5) rx_ident = {rx_ident[7:0], b};
        end
        byte_cnt = byte_cnt + 12'd1;
    endtask

    function automatic t_status classify_packet();
        int unsigned n;
        int unsigned hb;
        logic [16:0] sum;
        n   = byte_cnt;
        hb  = ihl * 4;
        sum = csum;
        if (n < IP_HDR_MIN_BYTES) return ST_SHORT;
        if (version != IP_VERSION_4) return ST_VERSION;
        if (hb < IP_HDR_MIN_BYTES || n < hb || n - hb < ICMP_HDR_BYTES) return ST_HDRLEN;
        if (proto != IP_PROTO_ICMP) return ST_PROTO;
        if (((n - hb) % 2) != 0) sum = fold_add(sum, {hi_hold, 8'h00});
        if (sum[15:0] != CSUM_GOOD) return ST_CSUM;
        if (icmp_type != ICMP_ECHO_REPLY || icmp_code != ICMP_CODE_ZERO || rx_ident != own_ident)
            return ST_NOTOURS;
        return ST_OK;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            own_ident = '0;
            clear_packet();
            verdict_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("unexpected result transaction: status %0d source_address %h",
                           i_res_status, i_res_source);
                    o_fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_res_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_res_status);
                        o_fail_count++;
                    end
                    if (i_res_source !== want.source) begin
                        $error("source_address: expected %h, actual %h", want.source, i_res_source);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_wr_en) own_ident = i_cfg_wr_data;
            if (i_pkt_valid && i_pkt_ready) begin
                if (byte_cnt < MAX_PACKET_BYTES) absorb_byte(i_pkt_data);
                if (i_pkt_last) begin
                    want.status = classify_packet();
                    want.source = src_addr;
                    verdict_q.push_back(want);
                    clear_packet();
                end
            end
        end
        o_pending = verdict_q.size();
    end

endmodule

### sim/icmp_echo_reply_filter_test.sv
`timescale 1ns / 100ps

module icmp_echo_reply_filter_test;
    import ierf_pkg::*;

    localparam int unsigned MAX_BYTES    = 2048;
    localparam int          RANDOM_BYTES = 1800;
    localparam int          QUIET_BYTES  = 300;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 500000;

    typedef enum int {
        DMG_BIT,
        DMG_VERSION,
        DMG_PROTO,
        DMG_TRIM,
        DMG_IHL
    } t_damage;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    int          fail_count;
    int          pending;
    logic [7:0]  frame[$];
    int          bytes_sent;
    bit          quiet;
    bit          hold_req;
    logic [15:0] echo_id;

    ierf_in_if  pkt_if();
    ierf_out_if res_if();

    icmp_echo_reply_filter #(
        .MAX_PACKET_BYTES(MAX_BYTES)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_pkt        (pkt_if),
        .o_res        (res_if)
    );

    icmp_echo_reply_filter_checker #(
        .MAX_PACKET_BYTES(MAX_BYTES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_pkt_valid  (pkt_if.valid),
        .i_pkt_ready  (pkt_if.ready),
        .i_pkt_data   (pkt_if.data_byte),
        .i_pkt_last   (pkt_if.last_byte),
        .i_res_valid  (res_if.valid),
        .i_res_ready  (res_if.ready),
        .i_res_status (res_if.status),
        .i_res_source (res_if.source_address),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    initial begin
        res_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 4);
            pkt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pkt_if.valid     <= 1'b1;
        pkt_if.data_byte <= b;
        pkt_if.last_byte <= last;
        @(posedge i_clk);
        while (!pkt_if.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
    endtask

    task automatic settle();
        pkt_if.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ident(input logic [15:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        echo_id = v;
    endtask

    task automatic trim_frame(input int n);
        while (frame.size() > n) void'(frame.pop_back());
    endtask

    task automatic fill_frame(input int n, input logic [7:0] b);
        frame.delete();
        repeat (n) frame.push_back(b);
    endtask

    task automatic build_reply(input int ihl, input int payload, input logic [15:0] ident,
                               input logic [7:0] icmp_type, input logic [7:0] icmp_code);
        int          hb;
        int          total;
        logic [16:0] s;
        logic [15:0] w;
        hb    = ihl * 4;
        total = hb + ICMP_HDR_BYTES + payload;
        frame.delete();
        for (int i = 0; i < total; i++) frame.push_back(8'($urandom));
        frame[0]      = {IP_VERSION_4, ihl[3:0]};
        frame[9]      = IP_PROTO_ICMP;
        frame[hb]     = icmp_type;
        frame[hb + 1] = icmp_code;
        frame[hb + 2] = 8'h00;
        frame[hb + 3] = 8'h00;
        frame[hb + 4] = ident[15:8];
        frame[hb + 5] = ident[7:0];
        s = '0;
        for (int i = hb; i < total; i += 2) begin
            w = {frame[i], (i + 1 < total) ? frame[i + 1] : 8'h00};
            s = s[15:0] + w;
            s = s[15:0] + s[16];
        end
        frame[hb + 2] = ~s[15:8];
        frame[hb + 3] = ~s[7:0];
    endtask

    task automatic random_frame();
        int pick;
        int idx;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            frame.delete();
            repeat ($urandom_range(1, 60)) frame.push_back(8'($urandom));
        end else begin
            build_reply(($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5,
                        ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                    : $urandom_range(0, 40),
                        ($urandom_range(0, 2) == 0) ? 16'($urandom) : echo_id,
                        ($urandom_range(0, 9) == 0) ? 8'($urandom) : ICMP_ECHO_REPLY,
                        ($urandom_range(0, 9) == 0) ? 8'($urandom) : ICMP_CODE_ZERO);
            if (pick >= 75) begin
                case (t_damage'($urandom_range(0, 4)))
                    DMG_BIT: begin
                        idx = $urandom_range(0, frame.size() - 1);
                        frame[idx] = frame[idx] ^ (8'd1 << $urandom_range(0, 7));
                    end
                    DMG_VERSION: frame[0] = {4'($urandom), frame[0][3:0]};
                    DMG_PROTO:   frame[9] = 8'($urandom);
                    DMG_TRIM:    trim_frame($urandom_range(1, frame.size() - 1));
                    default:     frame[0] = {frame[0][7:4], 4'($urandom)};
                endcase
            end
        end
    endtask

    initial begin
        int          rand_base;
        logic [15:0] phase_ident[4];
        pkt_if.valid     = 1'b0;
        pkt_if.data_byte = '0;
        pkt_if.last_byte = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        i_rst_n          = 1'b0;
        quiet            = 1'b0;
        hold_req         = 1'b0;
        echo_id          = '0;
        bytes_sent       = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_reply(5, 0, 16'h0000, ICMP_ECHO_REPLY, ICMP_CODE_ZERO);
        send_frame();
        build_reply(5, 1, 16'h0000, ICMP_ECHO_REPLY, ICMP_CODE_ZERO);
        send_frame();
        build_reply(15, 3, 16'h0000, ICMP_ECHO_REPLY, ICMP_CODE_ZERO);
        send_frame();
        build_reply(5, 0, 16'h0000, ICMP_ECHO_REPLY, ICMP_CODE_ZERO);
        trim_frame(19);
        send_frame();
        build_reply(5, 0, 16'h0000, ICMP_ECHO_REPLY, ICMP_CODE_ZERO);
        trim_frame(14);
        send_frame();
        build_reply(5, 0, 16'h0000, ICMP_ECHO_REPLY, ICMP_CODE_ZERO);
        trim_frame(1);
        send_frame();
        build_reply(5, 4, 16'h0000, ICMP_ECHO_REPLY, ICMP_CODE_ZERO);
        frame[0] = {4'd6, frame[0][3:0]};
        send_frame();
        build_reply(5, 8, 16'h0000, ICMP_ECHO_REPLY, ICMP_CODE_ZERO);
        frame[0] = {IP_VERSION_4, 4'd4};
        send_frame();
        build_reply(15, 0, 16'h0000, ICMP_ECHO_REPLY, ICMP_CODE_ZERO);
        trim_frame(67);
        send_frame();
        build_reply(5, 4, 16'h0000, ICMP_ECHO_REPLY, ICMP_CODE_ZERO);
        frame[9] = 8'd6;
        send_frame();
        build_reply(5, 16, 16'h0000, ICMP_ECHO_REPLY, ICMP_CODE_ZERO);
        frame[30] = frame[30] ^ 8'h01;
        send_frame();
        build_reply(5, 4, 16'h0000, 8'd8, ICMP_CODE_ZERO);
        send_frame();
        build_reply(5, 4, 16'h0000, ICMP_ECHO_REPLY, 8'd1);
        send_frame();
        build_reply(5, 4, 16'h1234, ICMP_ECHO_REPLY, ICMP_CODE_ZERO);
        send_frame();
        fill_frame(20, 8'hFF);
        send_frame();
        fill_frame(30, 8'h00);
        send_frame();
        build_reply(5, MAX_BYTES - 28, 16'h0000, ICMP_ECHO_REPLY, ICMP_CODE_ZERO);
        repeat (6) frame.push_back(8'($urandom));
        send_frame();

        write_ident(16'hFFFF);
        build_reply(5, 0, 16'hFFFF, ICMP_ECHO_REPLY, ICMP_CODE_ZERO);
        send_frame();
        build_reply(5, 0, 16'h0000, ICMP_ECHO_REPLY, ICMP_CODE_ZERO);
        send_frame();

        phase_ident[0] = 16'($urandom);
        phase_ident[1] = 16'h0000;
        phase_ident[2] = 16'hFFFF;
        phase_ident[3] = 16'($urandom);
        rand_base = bytes_sent;
        for (int p = 0; p < 4; p++) begin
            write_ident(phase_ident[p]);
            if (p == 1) hold_req = 1'b1;
            while (bytes_sent - rand_base < (p + 1) * RANDOM_BYTES / 4) begin
                if (bytes_sent - rand_base >= RANDOM_BYTES - QUIET_BYTES) quiet = 1'b1;
                random_frame();
                send_frame();
            end
        end

        settle();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
